// ----- rtl/ufp_pkg.sv -----
// Shared types, character codes and helpers for the form-encoded string parser.
`default_nettype none

package ufp_pkg;

    // Character codes that steer the parser.
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_PCT = 8'h25;

    // Result kinds.
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_NAME_LIMIT  = 1'b0;
    localparam logic CFG_VALUE_LIMIT = 1'b1;

    localparam int CNT_W = 10;

    localparam logic [CNT_W-1:0] NAME_LIMIT_RST  = 10'd32;
    localparam logic [CNT_W-1:0] VALUE_LIMIT_RST = 10'd128;

    // Escape decoder phase.
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX  = 2'd2
    } t_esc;

    // One input transaction.
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in;

    // One output transaction.
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_char;
        logic       out_run_end;
    } t_out;

    // Parser state carried from byte to byte.
    typedef struct packed {
        logic             value_part;
        t_esc             esc;
        logic [3:0]       hex_hi;
        logic [CNT_W-1:0] name_count;
        logic [CNT_W-1:0] value_count;
    } t_state;

    // Results caused by one byte: up to two, in order.
    typedef struct packed {
        t_out       first;
        t_out       second;
        logic [1:0] cnt;
    } t_res;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/urlencoded_form_parser.sv -----
// Top level of the streaming form-encoded string splitter and decoder.
`default_nettype none

// Takes one byte of a form-encoded string per input transaction and emits
// name bytes, percent-decoded value bytes and field-end marks, one result per
// output transaction. A byte is taken every cycle while results are taken as
// fast as they appear; a byte that causes two results (a data byte and the
// field end of the final byte) holds the input side back, since the two-entry
// result buffer must drain before new results enter. Parser state updates in
// the same cycle as the byte is accepted; the first result is visible in the
// cycle after acceptance. The user must write the limits through the
// configuration port only while the parser is idle; this is not enforced.
module urlencoded_form_parser (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_idx,
    input  wire [ufp_pkg::CNT_W-1:0]   i_cfg_data,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire ufp_pkg::t_in          i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output ufp_pkg::t_out              o_out_data
);

    logic [ufp_pkg::CNT_W-1:0] r_name_limit;
    logic [ufp_pkg::CNT_W-1:0] r_value_limit;
    ufp_pkg::t_state           r_state;
    ufp_pkg::t_state           n_state;
    ufp_pkg::t_res             res;
    logic                      can_push;
    logic                      accept;

    assign o_in_ready = can_push;
    assign accept     = i_in_valid && can_push;

    // Limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit  <= ufp_pkg::NAME_LIMIT_RST;
            r_value_limit <= ufp_pkg::VALUE_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ufp_pkg::CFG_NAME_LIMIT) begin
                r_name_limit <= i_cfg_data;
            end
            if (i_cfg_idx == ufp_pkg::CFG_VALUE_LIMIT) begin
                r_value_limit <= i_cfg_data;
            end
        end
    end

    // Parser state advances on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    ufp_step u_step (
        .i_in          (i_in_data),
        .i_state       (r_state),
        .i_name_limit  (r_name_limit),
        .i_value_limit (r_value_limit),
        .o_state       (n_state),
        .o_res         (res)
    );

    ufp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_res      (res),
        .o_can_push (can_push),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .i_ready    (i_out_ready)
    );

`ifndef ASSERT_OFF
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.in_last) |=> (r_state == '0))
        else $error("state not cleared after the final byte");
    a_esc_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.esc != ufp_pkg::ESC_NONE) |-> r_state.value_part)
        else $error("escape pending outside a value");
    a_amp_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.in_char == ufp_pkg::CH_AMP) |=>
            (o_out_valid && o_out_data.out_kind == ufp_pkg::KIND_END))
        else $error("ampersand did not produce a field end");
`endif

endmodule

`default_nettype wire

// ----- rtl/ufp_step.sv -----
// Next-state and result logic for one byte of the form-encoded string.
`default_nettype none

module ufp_step (
    input  wire ufp_pkg::t_in              i_in,
    input  wire ufp_pkg::t_state           i_state,
    input  wire [ufp_pkg::CNT_W-1:0]       i_name_limit,
    input  wire [ufp_pkg::CNT_W-1:0]       i_value_limit,
    output ufp_pkg::t_state                o_state,
    output ufp_pkg::t_res                  o_res
);

    logic [7:0]     c;
    logic [4:0]     hv;
    logic           data_vld;
    ufp_pkg::t_out  data;
    logic           fin_vld;
    ufp_pkg::t_state st;
    ufp_pkg::t_out  fin;

    assign c  = i_in.in_char;
    assign hv = ufp_pkg::hex_val(c);

    // Field split, limits and percent decoding.
    always_comb begin
        st       = i_state;
        data_vld = 1'b0;
        data     = '0;
        if (!i_state.value_part) begin
            if (c == ufp_pkg::CH_EQ) begin
                st.value_part = 1'b1;
            end else if (c == ufp_pkg::CH_AMP) begin
                data_vld      = 1'b1;
                data.out_kind = ufp_pkg::KIND_END;
                st            = '0;
            end else if (i_state.name_count < i_name_limit) begin
                st.name_count = i_state.name_count + 1'b1;
                data_vld      = 1'b1;
                data.out_kind = ufp_pkg::KIND_NAME;
                data.out_char = c;
            end
        end else begin
            if (c == ufp_pkg::CH_AMP) begin
                data_vld      = 1'b1;
                data.out_kind = ufp_pkg::KIND_END;
                st            = '0;
            end else if (i_state.value_count < i_value_limit) begin
                st.value_count = i_state.value_count + 1'b1;
                data.out_kind  = ufp_pkg::KIND_VALUE;
                unique case (i_state.esc)
                    ufp_pkg::ESC_NONE: begin
                        if (c == ufp_pkg::CH_PCT) begin
                            st.esc = ufp_pkg::ESC_PCT;
                        end else begin
                            data_vld      = 1'b1;
                            data.out_char = c;
                        end
                    end
                    ufp_pkg::ESC_PCT: begin
                        if (c != ufp_pkg::CH_PCT && hv[4]) begin
                            st.hex_hi = hv[3:0];
                            st.esc    = ufp_pkg::ESC_HEX;
                        end else begin
                            // A doubled percent or a non-hex byte passes as is.
                            data_vld      = 1'b1;
                            data.out_char = c;
                            st.esc        = ufp_pkg::ESC_NONE;
                        end
                    end
                    default: begin
                        data_vld      = 1'b1;
                        data.out_char = hv[4] ? {i_state.hex_hi, hv[3:0]} : c;
                        st.esc        = ufp_pkg::ESC_NONE;
                    end
                endcase
            end
        end

        // The final byte closes a field with a kept name, then clears all.
        fin_vld = 1'b0;
        if (i_in.in_last) begin
            fin_vld = (st.name_count != '0);
            st      = '0;
        end
    end

    assign fin.out_kind    = ufp_pkg::KIND_END;
    assign fin.out_char    = 8'd0;
    assign fin.out_run_end = 1'b1;

    // Order the results; the last one carries the run-end flag.
    always_comb begin
        o_res.second = fin;
        o_res.cnt    = {1'b0, data_vld} + {1'b0, fin_vld};
        if (data_vld) begin
            o_res.first             = data;
            o_res.first.out_run_end = !fin_vld;
        end else begin
            o_res.first = fin;
        end
    end

    assign o_state = st;

endmodule

`default_nettype wire

// ----- rtl/ufp_out_buf.sv -----
// Two-entry result buffer that drains one result per output transaction.
`default_nettype none

module ufp_out_buf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire ufp_pkg::t_res  i_res,
    output logic                o_can_push,
    output logic                o_valid,
    output ufp_pkg::t_out       o_data,
    input  wire                 i_ready
);

    logic [1:0]    r_cnt;
    ufp_pkg::t_out r_slot0;
    ufp_pkg::t_out r_slot1;
    logic          pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    // New results may enter only when the buffer drains fully this cycle.
    assign o_can_push = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_data     = r_slot0;

    // Occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push) begin
            r_cnt <= i_res.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Result slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot0 <= i_res.first;
            r_slot1 <= i_res.second;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer occupancy out of range");
    a_push_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && i_ready)))
        else $error("results pushed into an occupied buffer");
`endif

endmodule

`default_nettype wire

// ----- bench/ufp_stream_check.sv -----
// Checker for the form parser: predicts results from accepted bytes and compares them.
module ufp_stream_check (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_idx,
    input  wire [ufp_pkg::CNT_W-1:0]  i_cfg_data,
    input  wire                       i_in_valid,
    input  wire                       i_in_ready,
    input  ufp_pkg::t_in              i_in_data,
    input  wire                       i_out_valid,
    input  wire                       i_out_ready,
    input  ufp_pkg::t_out             i_out_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted parser state and limits.
    logic                      value_part;
    ufp_pkg::t_esc             esc_phase;
    logic [3:0]                high_nibble;
    logic [ufp_pkg::CNT_W-1:0] name_kept;
    logic [ufp_pkg::CNT_W-1:0] value_kept;
    logic [ufp_pkg::CNT_W-1:0] name_max;
    logic [ufp_pkg::CNT_W-1:0] value_max;

    // Results predicted but not yet seen on the output channel, oldest first.
    ufp_pkg::t_out awaited_results[$];

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c <= 8'h46) begin
            d = c - 8'h37;
        end else begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

    task automatic add_result(input logic [1:0] kind, input logic [7:0] ch);
        ufp_pkg::t_out r;
        r.out_kind    = kind;
        r.out_char    = ch;
        r.out_run_end = 1'b0;
        awaited_results.push_back(r);
    endtask

    task automatic clear_field();
        value_part  = 1'b0;
        esc_phase   = ufp_pkg::ESC_NONE;
        high_nibble = 4'd0;
        name_kept   = '0;
        value_kept  = '0;
    endtask

    // Percent decoding of one kept value byte.
    task automatic decode_value_byte(input logic [7:0] c);
        case (esc_phase)
            ufp_pkg::ESC_NONE: begin
                if (c == ufp_pkg::CH_PCT) begin
                    esc_phase = ufp_pkg::ESC_PCT;
                end else begin
                    add_result(ufp_pkg::KIND_VALUE, c);
                end
            end
            ufp_pkg::ESC_PCT: begin
                if (c == ufp_pkg::CH_PCT) begin
                    add_result(ufp_pkg::KIND_VALUE, ufp_pkg::CH_PCT);
                    esc_phase = ufp_pkg::ESC_NONE;
                end else if (is_hex(c)) begin
                    high_nibble = hex_nibble(c);
                    esc_phase   = ufp_pkg::ESC_HEX;
                end else begin
                    add_result(ufp_pkg::KIND_VALUE, c);
                    esc_phase = ufp_pkg::ESC_NONE;
                end
            end
            default: begin
                if (is_hex(c)) begin
                    add_result(ufp_pkg::KIND_VALUE, {high_nibble, hex_nibble(c)});
                end else begin
                    add_result(ufp_pkg::KIND_VALUE, c);
                end
                esc_phase = ufp_pkg::ESC_NONE;
            end
        endcase
    endtask

    // Splits one byte into name, value or field end and queues its results.
    task automatic parse_byte(input ufp_pkg::t_in item);
        int            count_before;
        ufp_pkg::t_out tail;
        count_before = awaited_results.size();
        if (item.in_char == ufp_pkg::CH_AMP) begin
            add_result(ufp_pkg::KIND_END, 8'h00);
            clear_field();
        end else if (!value_part) begin
            if (item.in_char == ufp_pkg::CH_EQ) begin
                value_part = 1'b1;
            end else if (name_kept < name_max) begin
                name_kept = name_kept + 1'b1;
                add_result(ufp_pkg::KIND_NAME, item.in_char);
            end
        end else if (value_kept < value_max) begin
            value_kept = value_kept + 1'b1;
            decode_value_byte(item.in_char);
        end
        // The final byte closes the field only when the name kept something.
        if (item.in_last) begin
            if (name_kept != '0) begin
                add_result(ufp_pkg::KIND_END, 8'h00);
            end
            clear_field();
        end
        if (awaited_results.size() > count_before) begin
            tail = awaited_results.pop_back();
            tail.out_run_end = 1'b1;
            awaited_results.push_back(tail);
        end
    endtask

    // Compare, then take configuration writes and new bytes at each edge.
    always @(posedge i_clk) begin : monitor
        ufp_pkg::t_out want;
        if (!i_rst_n) begin
            name_max  = ufp_pkg::NAME_LIMIT_RST;
            value_max = ufp_pkg::VALUE_LIMIT_RST;
            clear_field();
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result: expected none, got %0d/%h/%0d",
                             $time, i_out_data.out_kind, i_out_data.out_char,
                             i_out_data.out_run_end);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_data.out_kind !== want.out_kind ||
                        i_out_data.out_char !== want.out_char ||
                        i_out_data.out_run_end !== want.out_run_end) begin
                        o_fail_count++;
                        $display("%0t: result mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                                 $time, want.out_kind, want.out_char, want.out_run_end,
                                 i_out_data.out_kind, i_out_data.out_char,
                                 i_out_data.out_run_end);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == ufp_pkg::CFG_NAME_LIMIT) begin
                    name_max = i_cfg_data;
                end else begin
                    value_max = i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_in_data);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ----- bench/urlencoded_form_parser_test.sv -----
// Testbench top for the form parser: clock, reset, stimulus, limits and verdict.
module urlencoded_form_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_SLOW
    } t_rx_mode;

    typedef logic [ufp_pkg::CNT_W-1:0] t_limit;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_idx = ufp_pkg::CFG_NAME_LIMIT;
    t_limit           cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    ufp_pkg::t_in     in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    ufp_pkg::t_out    out_data;
    int               fail_count;
    int               pending;

    // Sender burst bookkeeping and receiver stall pattern.
    int               burst_left = 0;
    t_rx_mode         rx_mode = RX_STEADY;
    int               rx_left = 0;

    // Bytes of the form string being built.
    logic [7:0]       form_bytes[$];

    always #5 clk = ~clk;

    urlencoded_form_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    ufp_stream_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: switches between steady, choppy and slow stretches.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            RX_STEADY: out_ready <= 1'b1;
            RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
            default:   out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // One input transaction; starts and ends at a falling edge.
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{in_char: c, in_last: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], close && (i == s.len() - 1));
        end
    endtask

    // Stops sending and waits until every predicted result has come out.
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0 && guard < 5000) begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic set_limits(input t_limit name_lim, input t_limit value_lim);
        cfg_we   <= 1'b1;
        cfg_idx  <= ufp_pkg::CFG_NAME_LIMIT;
        cfg_data <= name_lim;
        @(negedge clk);
        cfg_idx  <= ufp_pkg::CFG_VALUE_LIMIT;
        cfg_data <= value_lim;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return 8'h30 + d;
        end else if ($urandom_range(0, 1) == 1) begin
            return 8'h37 + d;
        end else begin
            return 8'h57 + d;
        end
    endfunction

    function automatic logic [7:0] name_char();
        if ($urandom_range(0, 15) == 0) begin
            return 8'($urandom_range(1, 255));
        end else if ($urandom_range(0, 3) == 0) begin
            return 8'h30 + 8'($urandom_range(0, 9));
        end else begin
            return 8'h61 + 8'($urandom_range(0, 25));
        end
    endfunction

    // Appends one piece of a value: plain bytes, good escapes or broken ones.
    task automatic add_value_piece();
        case ($urandom_range(0, 7))
            0, 1: form_bytes.push_back(name_char());
            2, 3: begin
                form_bytes.push_back(ufp_pkg::CH_PCT);
                form_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
                form_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            4: begin
                form_bytes.push_back(ufp_pkg::CH_PCT);
                form_bytes.push_back(ufp_pkg::CH_PCT);
            end
            5: begin
                form_bytes.push_back(ufp_pkg::CH_PCT);
                form_bytes.push_back(8'h67 + 8'($urandom_range(0, 19)));
            end
            6: begin
                form_bytes.push_back(ufp_pkg::CH_PCT);
                form_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
                form_bytes.push_back(8'h67 + 8'($urandom_range(0, 19)));
            end
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    form_bytes.push_back(ufp_pkg::CH_EQ);
                end else begin
                    form_bytes.push_back(8'($urandom_range(1, 255)));
                end
            end
        endcase
    endtask

    // Builds one string: mostly name=value fields, some raw noise.
    task automatic make_form();
        int n_fields;
        int len;
        form_bytes.delete();
        n_fields = $urandom_range(1, 4);
        for (int i = 0; i < n_fields; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) form_bytes.push_back(8'($urandom_range(1, 255)));
            end else begin
                len = $urandom_range(0, 5);
                repeat (len) form_bytes.push_back(name_char());
                if ($urandom_range(0, 7) != 0) begin
                    form_bytes.push_back(ufp_pkg::CH_EQ);
                    len = $urandom_range(0, 5);
                    repeat (len) add_value_piece();
                end
            end
            if (i != n_fields - 1 || $urandom_range(0, 3) == 0) begin
                form_bytes.push_back(ufp_pkg::CH_AMP);
            end
        end
        if (form_bytes.size() == 0) begin
            form_bytes.push_back(name_char());
        end
    endtask

    task automatic run_forms(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            make_form();
            foreach (form_bytes[k]) begin
                send_byte(form_bytes[k], k == form_bytes.size() - 1);
            end
            sent += form_bytes.size();
        end
    endtask

    // Main sequence: directed strings, then random forms under several limits.
    initial begin
        t_limit name_lims[8];
        t_limit value_lims[8];
        name_lims  = '{10'd32,  10'd0, 10'd1023, 10'd2, 10'd1, 10'd0, 10'd5,    10'd1023};
        value_lims = '{10'd128, 10'd0, 10'd1023, 10'd3, 10'd1, 10'd0, 10'd1023, 10'd0};
        name_lims[5]  = t_limit'($urandom_range(0, 12));
        value_lims[5] = t_limit'($urandom_range(0, 12));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Escapes of every kind, '=' inside a value, and a final '&'.
        send_text("a=%%%fF%4z%q=&", 1'b1);
        // Empty name at end of string, with a partial escape left open.
        send_text("=x%4", 1'b1);
        // Extreme bytes, a zero byte, and a final byte that causes two results.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ufp_pkg::CH_EQ, 1'b0);
        send_byte(8'h80, 1'b1);
        // Partial escape dropped when '&' closes the field.
        send_text("k=%&", 1'b0);

        run_forms(55);
        for (int p = 1; p < 8; p++) begin
            wait_for_drain();
            set_limits(name_lims[p], value_lims[p]);
            run_forms(55);
        end
        wait_for_drain();

        if (fail_count == 0 && pending == 0) begin
            $display("[urlencoded_form_parser] OK");
        end else begin
            $display("[urlencoded_form_parser] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4_000_000;
        $display("[urlencoded_form_parser] ERROR");
        $finish;
    end

endmodule
